// File: hw/rtl/lhm_pkg.sv
`timescale 1ns / 1ps
package lhm_pkg;

    localparam int CHANNELS = 3;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int FUNC_W = 2;
    localparam int CHAN_W = 2;
    localparam int ADC_W  = 12;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;
    localparam int ADDR_W = 2;
    localparam int DATA_W = 12;

    localparam logic [FUNC_W-1:0] FN_CHECK = 2'd0;
    localparam logic [FUNC_W-1:0] FN_OPEN  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RESET = 2'd2;

    localparam logic [STAT_W-1:0] ST_NORMAL  = 2'd0;
    localparam logic [STAT_W-1:0] ST_SKIP    = 2'd1;
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

    localparam logic [ADDR_W-1:0] REG_CUR_THR = 2'd0;
    localparam logic [ADDR_W-1:0] REG_PD_THR  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_CONFIRM = 2'd2;
    localparam logic [ADDR_W-1:0] REG_WINDOW  = 2'd3;

    localparam logic [ADC_W-1:0] CUR_THR_RST = 12'd20;
    localparam logic [ADC_W-1:0] PD_THR_RST  = 12'd100;
    localparam logic [CNT_W-1:0] CONFIRM_RST = 8'd3;
    localparam logic [CNT_W-1:0] WINDOW_RST  = 8'd3;

    typedef struct packed {
        logic [ADC_W-1:0] current_threshold_ma;
        logic [ADC_W-1:0] pd_threshold;
        logic [CNT_W-1:0] confirm_count;
        logic [CNT_W-1:0] open_window_cycles;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAN_W-1:0] channel;
        logic [ADC_W-1:0]  pd_level;
        logic [ADC_W-1:0]  drive_ma;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              power_off;
    } t_result;

endpackage

// File: hw/rtl/lhm_if.sv
`timescale 1ns / 1ps
interface lhm_item_if;
    logic                       valid;
    logic                       ready;
    logic [lhm_pkg::FUNC_W-1:0] func;
    logic [lhm_pkg::CHAN_W-1:0] channel;
    logic [lhm_pkg::ADC_W-1:0]  pd_level;
    logic [lhm_pkg::ADC_W-1:0]  drive_ma;

    modport source(output valid, func, channel, pd_level, drive_ma, input ready);
    modport sink(input valid, func, channel, pd_level, drive_ma, output ready);
endinterface

interface lhm_res_if;
    logic                       valid;
    logic                       ready;
    logic [lhm_pkg::STAT_W-1:0] status;
    logic                       power_off;

    modport source(output valid, status, power_off, input ready);
    modport sink(input valid, status, power_off, output ready);
endinterface

interface lhm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lhm_pkg::ADDR_W-1:0] addr;
    logic [lhm_pkg::DATA_W-1:0] data;

    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface

// File: hw/rtl/lhm_cfg_regs.sv
`timescale 1ns / 1ps
module lhm_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lhm_cfg_if.sink       i_cfg,
    output lhm_pkg::t_cfg o_cfg
);

    lhm_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_threshold_ma <= lhm_pkg::CUR_THR_RST;
            r_cfg.pd_threshold         <= lhm_pkg::PD_THR_RST;
            r_cfg.confirm_count        <= lhm_pkg::CONFIRM_RST;
            r_cfg.open_window_cycles   <= lhm_pkg::WINDOW_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                lhm_pkg::REG_CUR_THR: r_cfg.current_threshold_ma <= i_cfg.data;
                lhm_pkg::REG_PD_THR:  r_cfg.pd_threshold         <= i_cfg.data;
                lhm_pkg::REG_CONFIRM: r_cfg.confirm_count        <= i_cfg.data[lhm_pkg::CNT_W-1:0];
                lhm_pkg::REG_WINDOW:  r_cfg.open_window_cycles   <= i_cfg.data[lhm_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/lhm_core.sv
`timescale 1ns / 1ps
module lhm_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  lhm_pkg::t_item   i_item,
    input  lhm_pkg::t_cfg    i_cfg,
    output lhm_pkg::t_result o_res
);

    logic [lhm_pkg::CNT_W-1:0]    r_uc [lhm_pkg::CHANNELS];
    logic [lhm_pkg::CNT_W-1:0]    r_cd [lhm_pkg::CHANNELS];
    logic [lhm_pkg::CHANNELS-1:0] r_ev;

    logic                      w_valid;
    logic                      w_check;
    logic [lhm_pkg::CH_W-1:0]  w_idx;
    logic [lhm_pkg::CH_W-1:0]  w_next_ch;
    logic [lhm_pkg::CNT_W-1:0] w_uc;
    logic [lhm_pkg::CNT_W-1:0] w_cd;
    logic                      w_ev;
    logic                      w_cond;
    logic [lhm_pkg::CNT_W-1:0] n_uc;
    logic [lhm_pkg::CNT_W-1:0] n_cd;
    logic                      n_ev;
    logic [lhm_pkg::STAT_W-1:0] w_status;
    logic                      w_poff;

    assign w_valid = (int'(i_item.channel) < lhm_pkg::CHANNELS)
                     && ((i_item.func == lhm_pkg::FN_CHECK)
                     || (i_item.func == lhm_pkg::FN_OPEN)
                     || (i_item.func == lhm_pkg::FN_RESET));
    assign w_check = (i_item.func == lhm_pkg::FN_CHECK);

    // commands act on the following channel, wrapping at the top
    assign w_next_ch = (int'(i_item.channel) + 1 >= lhm_pkg::CHANNELS) ? '0
                       : lhm_pkg::CH_W'(int'(i_item.channel) + 1);
    assign w_idx = w_check ? lhm_pkg::CH_W'(i_item.channel) : w_next_ch;

    assign w_uc   = r_uc[w_idx];
    assign w_cd   = r_cd[w_idx];
    assign w_ev   = r_ev[w_idx];
    assign w_cond = (i_item.drive_ma >= i_cfg.current_threshold_ma);

    always_comb begin
        n_uc     = w_uc;
        n_cd     = w_cd;
        n_ev     = w_ev;
        w_status = lhm_pkg::ST_IGNORED;
        w_poff   = 1'b0;
        if (w_valid) begin
            if (w_check) begin
                if (w_cd != '0) begin
                    n_cd = w_cd - 1'b1;
                end
                if (w_cond && !w_ev && n_cd == '0) begin
                    w_poff = 1'b1;
                end
                if (i_item.pd_level < i_cfg.pd_threshold) begin
                    if (!w_cond) begin
                        if (w_ev && w_uc < i_cfg.confirm_count) begin
                            n_uc = w_uc + 1'b1;
                            if (n_uc >= i_cfg.confirm_count) begin
                                w_poff = 1'b1;
                            end
                        end
                    end else begin
                        n_uc = '0;
                        n_ev = 1'b1;
                    end
                    w_status = lhm_pkg::ST_SKIP;
                end else begin
                    n_uc = '0;
                    if (w_cond) begin
                        n_ev = 1'b1;
                    end
                    w_status = lhm_pkg::ST_NORMAL;
                end
            end else begin
                n_uc     = '0;
                n_ev     = 1'b0;
                n_cd     = (i_item.func == lhm_pkg::FN_OPEN) ? i_cfg.open_window_cycles : '0;
                w_status = lhm_pkg::ST_DONE;
            end
        end
    end

    assign o_res.status    = w_status;
    assign o_res.power_off = w_poff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lhm_pkg::CHANNELS; i++) begin
                r_uc[i] <= '0;
                r_cd[i] <= '0;
            end
            r_ev <= '0;
        end else if (i_fire && w_valid) begin
            r_uc[w_idx] <= n_uc;
            r_cd[w_idx] <= n_cd;
            r_ev[w_idx] <= n_ev;
        end
    end

    a_ignored_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !w_valid) |=> $stable(r_ev))
        else $error("ignored word changed connection state");

    a_cmd_no_poff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid && !w_check) |-> (!w_poff && w_status == lhm_pkg::ST_DONE))
        else $error("command word produced power-off or wrong status");

    a_skip_on_low_pd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid && w_check && i_item.pd_level < i_cfg.pd_threshold)
        |-> (w_status == lhm_pkg::ST_SKIP))
        else $error("low photodiode check not flagged as skip");

endmodule

// File: hw/rtl/laser_hotplug_monitor.sv
`timescale 1ns / 1ps
// Laser hot-plug monitor for lhm_pkg::CHANNELS channels. One word is accepted every clock
// cycle unless stalled; each input word yields exactly one result word through the input
// register, then the result register, set by the per-channel state update between them.
// Back-pressure on the result side stalls the input side only once both registers are full.
// Configuration writes are taken at any time but must only be issued while idle.
module laser_hotplug_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lhm_item_if.sink   i_item,
    lhm_res_if.source  o_res,
    lhm_cfg_if.sink    i_cfg
);

    lhm_pkg::t_cfg    w_cfg;
    lhm_pkg::t_item   r_item;
    lhm_pkg::t_result w_res;
    lhm_pkg::t_result r_res;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             w_adv;
    logic             w_fire;

    lhm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    lhm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_adv        = !r_out_valid || o_res.ready;
    assign w_fire       = r_in_valid && w_adv;
    assign i_item.ready = !r_in_valid || w_adv;

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_res.status;
    assign o_res.power_off = r_res.power_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_item.func     <= i_item.func;
            r_item.channel  <= i_item.channel;
            r_item.pd_level <= i_item.pd_level;
            r_item.drive_ma <= i_item.drive_ma;
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_res.ready) |-> !i_item.ready)
        else $error("input accepted while both stages are full");

    a_poff_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.power_off)
        |-> (r_res.status == lhm_pkg::ST_NORMAL || r_res.status == lhm_pkg::ST_SKIP))
        else $error("power-off on a word that is not a check");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule
